[rtl/amrdp_pkg.sv]
package amrdp_pkg;

    // Default payload buffer depth in bytes.
    localparam int AMRDP_MAX_PAYLOAD_DEFAULT = 64;

    // Configuration register indexes.
    localparam logic [1:0] REG_OCTET_ALIGNED = 2'd0;
    localparam logic [1:0] REG_ALLOWED_MODES = 2'd1;
    localparam logic [1:0] REG_DEFAULT_MODE  = 2'd2;

    // Frame status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TOO_SHORT = 2'd1;
    localparam logic [1:0] STATUS_BAD_HDR   = 2'd2;
    localparam logic [1:0] STATUS_BAD_LEN   = 2'd3;

    // Header bit masks.
    localparam logic [7:0] OA_HDR_MASK  = 8'h84;
    localparam logic [7:0] OA_HDR_VALUE = 8'h04;

    // Header bits plus rounding to whole bytes, in each payload format.
    localparam logic [8:0] OA_LEN_BIAS = 9'd23;
    localparam logic [8:0] BE_LEN_BIAS = 9'd17;

    // Speech bits per frame type.
    localparam logic [7:0] FRAME_BITS [16] = '{
        8'd95, 8'd103, 8'd118, 8'd134, 8'd148, 8'd159, 8'd204, 8'd244,
        8'd39, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // input transaction taken this cycle
        logic load_check;  // load the header or error result
        logic rd_en;       // read the next payload byte
        logic load_data;   // load one speech byte result
    } amrdp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;    // output register can take a result
        logic chk_last;    // the header or error result ends the payload
        logic dat_last;    // the current speech byte ends the payload
    } amrdp_sts_t;

endpackage

[rtl/amr_rtp_payload_depacketizer_unit.sv]
// AMR-NB RTP payload depacketizer for single-frame payloads. Payload bytes enter one per
// cycle on the slave stream while a payload is being collected, tlast marking the final
// byte, and are buffered in a MAX_PAYLOAD_BYTES deep single-port memory; bytes beyond that
// depth are dropped and the frame then fails its length check. After the last byte the
// block checks the header, then emits the storage-format frame: a header byte
// (frame type << 3 | 4) followed by the speech bytes, copied in octet-aligned mode or
// moved up by two bits in bandwidth-efficient mode. Each speech byte is first read from
// the payload memory and then loaded into the output register, which waits on
// back-pressure; the next payload is taken only after the last result is loaded.
// A short payload, a bad header or a wrong length gives a single result carrying the
// error in m_tuser.
// A good frame with a mode request below 8 moves the current codec mode to the highest
// allowed mode at or below the request. Configuration writes are taken every cycle and
// must only be issued while no payload is in progress.
module amr_rtp_payload_depacketizer_unit #(
    parameter int MAX_PAYLOAD_BYTES = amrdp_pkg::AMRDP_MAX_PAYLOAD_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // Payload input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] payload_byte
    input  logic        s_tlast,   // last_byte
    // Storage-format output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] storage_byte, [11:8] frame_type,
                                   // [15:12] requested_mode, [18:16] active_mode
    output logic        m_tlast,   // result_last
    output logic [1:0]  m_tuser    // [1:0] frame_status
);
    import amrdp_pkg::*;

    amrdp_cmd_t cmd;
    amrdp_sts_t sts;
    logic [7:0] out_byte;
    logic [1:0] out_status;
    logic [3:0] out_type;
    logic [3:0] out_req;
    logic [2:0] out_mode;

    assign cfg_ready = 1'b1;

    amrdp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    amrdp_datapath #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_byte   (out_byte),
        .out_last   (m_tlast),
        .out_status (out_status),
        .out_type   (out_type),
        .out_req    (out_req),
        .out_mode   (out_mode),
        .cmd        (cmd),
        .sts        (sts)
    );

    // Pack the result fields, highest field first.
    assign m_tdata = {5'd0, out_mode, out_req, out_type, out_byte};
    assign m_tuser = out_status;

endmodule

[rtl/amrdp_ctrl.sv]
module amrdp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tlast,
    output logic                  s_tready,
    input  amrdp_pkg::amrdp_sts_t sts,
    output amrdp_pkg::amrdp_cmd_t cmd
);
    import amrdp_pkg::*;

    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_CHECK   = 2'd1;
    localparam logic [1:0] ST_READ    = 2'd2;
    localparam logic [1:0] ST_EMIT    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Bytes are taken only while a payload is being collected.
    assign s_tready = (state_reg == ST_COLLECT);

    // Next state and command decode.
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_COLLECT: begin
                cmd.accept = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.out_free) begin
                    cmd.load_check = 1'b1;
                    state_next     = sts.chk_last ? ST_COLLECT : ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.load_data = 1'b1;
                    state_next    = sts.dat_last ? ST_COLLECT : ST_READ;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/amrdp_datapath.sv]
module amrdp_datapath #(
    parameter int MAX_PAYLOAD_BYTES = amrdp_pkg::AMRDP_MAX_PAYLOAD_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration writes
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    // Input payload byte
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    // Output stream
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [7:0]            out_byte,
    output logic                  out_last,
    output logic [1:0]            out_status,
    output logic [3:0]            out_type,
    output logic [3:0]            out_req,
    output logic [2:0]            out_mode,
    // Controller link
    input  amrdp_pkg::amrdp_cmd_t cmd,
    output amrdp_pkg::amrdp_sts_t sts
);
    import amrdp_pkg::*;

    localparam int AW = $clog2(MAX_PAYLOAD_BYTES);
    localparam int CW = $clog2(MAX_PAYLOAD_BYTES + 2);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PAYLOAD_BYTES);

    // Configuration and mode state.
    logic       octet_reg;
    logic [7:0] allowed_reg;
    logic [2:0] mode_reg;
    logic [2:0] mode_next;

    // Payload buffer and collection state.
    logic [7:0]    store_mem [MAX_PAYLOAD_BYTES];
    logic [7:0]    rd_data_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] len_reg;
    logic [7:0]    byte0_reg;
    logic [7:0]    byte1_reg;

    // Emission state.
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_plus;
    logic [7:0]    prev_reg;
    logic [3:0]    ft_reg;
    logic [3:0]    req_reg;
    logic          need_read;

    // Output register.
    logic          valid_reg;
    logic [7:0]    obyte_reg;
    logic          olast_reg;
    logic [1:0]    ostat_reg;
    logic [3:0]    otype_reg;
    logic [3:0]    oreq_reg;
    logic [2:0]    omode_reg;
    logic          out_free;

    // Header check.
    logic [3:0]    chk_req;
    logic [3:0]    chk_ft;
    logic          chk_bad_hdr;
    logic [8:0]    chk_sum;
    logic [5:0]    chk_need;
    logic [1:0]    chk_status;
    logic          chk_ok;

    assign out_free = !valid_reg || m_tready;
    assign cnt_inc  = (cnt_reg <= CNT_MAX) ? CW'(cnt_reg + 1'b1) : cnt_reg;
    assign idx_plus = CW'(idx_reg + 1'b1);

    // Decode the payload header in the selected format.
    always_comb begin
        chk_req = byte0_reg[7:4];
        if (octet_reg) begin
            chk_bad_hdr = (byte1_reg & OA_HDR_MASK) != OA_HDR_VALUE;
            chk_ft      = byte1_reg[6:3];
            chk_sum     = 9'(FRAME_BITS[chk_ft]) + OA_LEN_BIAS;
        end else begin
            chk_bad_hdr = byte0_reg[3] || !byte1_reg[6];
            chk_ft      = {byte0_reg[2:0], byte1_reg[7]};
            chk_sum     = 9'(FRAME_BITS[chk_ft]) + BE_LEN_BIAS;
        end
        chk_need = chk_sum[8:3];
        priority if (len_reg < CW'(2)) begin
            chk_status = STATUS_TOO_SHORT;
        end else if (chk_bad_hdr) begin
            chk_status = STATUS_BAD_HDR;
        end else if (len_reg != CW'(chk_need)) begin
            chk_status = STATUS_BAD_LEN;
        end else begin
            chk_status = STATUS_OK;
        end
        chk_ok = (chk_status == STATUS_OK);
    end

    // Highest allowed mode at or below the request; an ascending scan keeps the last hit.
    always_comb begin
        mode_next = mode_reg;
        if (!chk_req[3]) begin
            for (int m = 0; m < 8; m++) begin
                if (4'(m) <= chk_req && allowed_reg[m]) begin
                    mode_next = 3'(m);
                end
            end
        end
    end

    // In the compact format the last speech byte has no follower to borrow bits from.
    assign need_read = octet_reg || (idx_plus < len_reg);

    assign sts.out_free = out_free;
    assign sts.chk_last = !chk_ok || (octet_reg && len_reg == CW'(2));
    assign sts.dat_last = (idx_plus == len_reg);

    // Configuration registers and the current codec mode.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            octet_reg   <= 1'b0;
            allowed_reg <= 8'hFF;
            mode_reg    <= 3'd7;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_OCTET_ALIGNED: octet_reg   <= cfg_data[0];
                    REG_ALLOWED_MODES: allowed_reg <= cfg_data;
                    REG_DEFAULT_MODE:  mode_reg    <= cfg_data[2:0];
                    default: ;
                endcase
            end
            if (cmd.load_check && chk_ok) begin
                mode_reg <= mode_next;
            end
        end
    end

    // Byte counter with saturation one above the buffer depth.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.accept) begin
            cnt_reg <= in_last ? '0 : cnt_inc;
        end
    end

    // Payload buffer writes, header byte copies and the frame length.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            if (cnt_reg < CNT_MAX) begin
                store_mem[cnt_reg[AW-1:0]] <= in_byte;
            end
            if (cnt_reg == CW'(0)) begin
                byte0_reg <= in_byte;
            end
            if (cnt_reg == CW'(1)) begin
                byte1_reg <= in_byte;
            end
            if (in_last) begin
                len_reg <= cnt_inc;
            end
        end
    end

    // Registered buffer read.
    always_ff @(posedge aclk) begin
        if (cmd.rd_en && need_read) begin
            rd_data_reg <= octet_reg ? store_mem[idx_reg[AW-1:0]]
                                     : store_mem[idx_plus[AW-1:0]];
        end
    end

    // Speech byte walk.
    always_ff @(posedge aclk) begin
        if (cmd.load_check) begin
            idx_reg  <= octet_reg ? CW'(2) : CW'(1);
            prev_reg <= byte1_reg;
            ft_reg   <= chk_ft;
            req_reg  <= chk_req;
        end else if (cmd.load_data) begin
            idx_reg  <= idx_plus;
            prev_reg <= rd_data_reg;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.load_check || cmd.load_data) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (cmd.load_check) begin
            olast_reg <= sts.chk_last;
            ostat_reg <= chk_status;
            omode_reg <= chk_ok ? mode_next : mode_reg;
            unique case (chk_status)
                STATUS_OK: begin
                    obyte_reg <= {1'b0, chk_ft, 3'b100};
                    otype_reg <= chk_ft;
                    oreq_reg  <= chk_req;
                end
                STATUS_TOO_SHORT: begin
                    obyte_reg <= 8'd0;
                    otype_reg <= 4'd0;
                    oreq_reg  <= 4'd0;
                end
                STATUS_BAD_HDR: begin
                    obyte_reg <= 8'd0;
                    otype_reg <= 4'd0;
                    oreq_reg  <= chk_req;
                end
                default: begin
                    obyte_reg <= 8'd0;
                    otype_reg <= chk_ft;
                    oreq_reg  <= chk_req;
                end
            endcase
        end else if (cmd.load_data) begin
            olast_reg <= sts.dat_last;
            ostat_reg <= STATUS_OK;
            otype_reg <= ft_reg;
            oreq_reg  <= req_reg;
            omode_reg <= mode_reg;
            if (octet_reg) begin
                obyte_reg <= rd_data_reg;
            end else begin
                obyte_reg <= {prev_reg[5:0], need_read ? rd_data_reg[7:6] : 2'b00};
            end
        end
    end

    assign m_tvalid   = valid_reg;
    assign out_byte   = obyte_reg;
    assign out_last   = olast_reg;
    assign out_status = ostat_reg;
    assign out_type   = otype_reg;
    assign out_req    = oreq_reg;
    assign out_mode   = omode_reg;

endmodule

[tb/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import amrdp_pkg::*;

    localparam int PAYLOAD_DEPTH = 64;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 240;
    localparam int PHASES        = 6;

    // One storage-format output transaction as the block should produce it.
    typedef struct packed {
        logic [7:0] sbyte;
        logic       fin;
        logic [1:0] status;
        logic [3:0] ftype;
        logic [3:0] cmr;
        logic [2:0] mode;
    } storage_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_OCTET_ALIGNED;
    logic [7:0]  cfg_data  = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;   // [7:0] payload_byte
    logic        s_tlast   = 1'b0;    // last_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;             // [7:0] storage_byte, [11:8] frame_type,
                                      // [15:12] requested_mode, [18:16] active_mode
    logic        m_tlast;             // result_last
    logic [1:0]  m_tuser;             // [1:0] frame_status

    amr_rtp_payload_depacketizer_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // Depacketizer state as the testbench tracks it.
    logic [7:0] pl_buf [PAYLOAD_DEPTH];
    logic [6:0] pl_count;
    logic [2:0] cur_mode;
    logic       oa_mode;
    logic [7:0] allowed_modes;

    storage_result_t pending_storage[$];
    logic [7:0]      frame_q[$];

    int  mismatches      = 0;
    int  results_checked = 0;
    int  items_sent      = 0;
    int  payloads_sent   = 0;
    int  good_frames     = 0;
    int  short_frames    = 0;
    int  hdr_errors      = 0;
    int  len_errors      = 0;
    int  cfg_writes      = 0;
    int  cycle_count     = 0;
    int  stall_left      = 0;
    bit  quiet           = 1'b0;

    // Free-running clock.
    initial begin
        forever #2 aclk = ~aclk;
    end

    // Payload length in bytes that a frame type needs in the given format.
    function automatic int frame_len(logic oa, logic [3:0] ft);
        int bits;
        case (ft)
            4'd0:    bits = 95;
            4'd1:    bits = 103;
            4'd2:    bits = 118;
            4'd3:    bits = 134;
            4'd4:    bits = 148;
            4'd5:    bits = 159;
            4'd6:    bits = 204;
            4'd7:    bits = 244;
            4'd8:    bits = 39;
            default: bits = 0;
        endcase
        return ((oa ? 16 : 10) + bits + 7) / 8;
    endfunction

    function automatic void expect_result(logic [7:0] sb, logic fin, logic [1:0] st,
                                          logic [3:0] ft, logic [3:0] cmr);
        storage_result_t r;
        r = '{sb, fin, st, ft, cmr, cur_mode};
        pending_storage.push_back(r);
    endfunction

    // Buffer one payload byte; on the last byte check the header and queue the
    // storage-format bytes or the single error result.
    function automatic void depacketize_byte(logic [7:0] data, logic fin);
        int         len;
        int         need;
        logic [3:0] cmr;
        logic [3:0] ft;
        logic [7:0] sb;
        if (pl_count < PAYLOAD_DEPTH) pl_buf[pl_count[5:0]] = data;
        if (pl_count <= PAYLOAD_DEPTH) pl_count = pl_count + 7'd1;
        if (!fin) return;

        len = int'(pl_count);
        pl_count = 7'd0;
        payloads_sent++;
        if (len < 2) begin
            expect_result(8'h00, 1'b1, STATUS_TOO_SHORT, 4'd0, 4'd0);
            short_frames++;
            return;
        end
        cmr = pl_buf[0][7:4];

        // Header check: F must be clear and Q must be set in either format.
        if (oa_mode) begin
            if (pl_buf[1][7] || !pl_buf[1][2]) begin
                expect_result(8'h00, 1'b1, STATUS_BAD_HDR, 4'd0, cmr);
                hdr_errors++;
                return;
            end
            ft = pl_buf[1][6:3];
        end else begin
            if (pl_buf[0][3] || !pl_buf[1][6]) begin
                expect_result(8'h00, 1'b1, STATUS_BAD_HDR, 4'd0, cmr);
                hdr_errors++;
                return;
            end
            ft = {pl_buf[0][2:0], pl_buf[1][7]};
        end
        need = frame_len(oa_mode, ft);
        if (len != need) begin
            expect_result(8'h00, 1'b1, STATUS_BAD_LEN, ft, cmr);
            len_errors++;
            return;
        end

        // Mode request: highest allowed mode at or below the request, if any.
        if (cmr < 4'd8) begin
            for (int m = int'(cmr); m >= 0; m--) begin
                if (allowed_modes[m]) begin
                    cur_mode = m[2:0];
                    break;
                end
            end
        end
        good_frames++;

        expect_result({1'b0, ft, 3'b100}, oa_mode && (len == 2), STATUS_OK, ft, cmr);
        if (oa_mode) begin
            for (int i = 2; i < len; i++)
                expect_result(pl_buf[i], i == len - 1, STATUS_OK, ft, cmr);
        end else begin
            for (int i = 1; i < len; i++) begin
                sb = {pl_buf[i][5:0], 2'b00};
                if (i + 1 < len) sb[1:0] = pl_buf[i + 1][7:6];
                expect_result(sb, i == len - 1, STATUS_OK, ft, cmr);
            end
        end
    endfunction

    // Fill frame_q with a well-formed payload of random speech content.
    function automatic void build_frame(logic oa, logic [3:0] ft, logic [3:0] cmr);
        logic [7:0] b0;
        logic [7:0] b1;
        int         need;
        need = frame_len(oa, ft);
        b0 = 8'($urandom_range(0, 255));
        b1 = 8'($urandom_range(0, 255));
        b0[7:4] = cmr;
        if (oa) begin
            b1[7]   = 1'b0;
            b1[6:3] = ft;
            b1[2]   = 1'b1;
        end else begin
            b0[3]   = 1'b0;
            b0[2:0] = ft[3:1];
            b1[7]   = ft[0];
            b1[6]   = 1'b1;
        end
        frame_q.delete();
        frame_q.push_back(b0);
        frame_q.push_back(b1);
        for (int i = 2; i < need; i++) frame_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR at %0t ns, result %0d: %s is 0x%0h, expected 0x%0h",
                 $time, results_checked, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want) report_mismatch(name, got, want);
    endtask

    // Send one payload byte, with an occasional random gap before it.
    task automatic send_item(logic [7:0] data, logic fin);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        depacketize_byte(data, fin);
        items_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_item(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Stop sending and wait until every expected result has been seen.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_storage.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_OCTET_ALIGNED: oa_mode = value[0];
            REG_ALLOWED_MODES: allowed_modes = value;
            REG_DEFAULT_MODE:  cur_mode = value[2:0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge aclk);
    endtask

    task automatic configure(logic oa, logic [7:0] allowed, logic [2:0] dmode, bit load_mode);
        write_reg(REG_OCTET_ALIGNED, {7'd0, oa});
        write_reg(REG_ALLOWED_MODES, allowed);
        if (load_mode) write_reg(REG_DEFAULT_MODE, {5'd0, dmode});
    endtask

    // Too-short payloads, header errors and a length error in bandwidth-efficient mode at reset settings.
    task automatic test_short_and_bad_headers();
        frame_q = '{8'hFF};
        send_frame();
        frame_q = '{8'h00};
        send_frame();
        // F bit set
        frame_q = '{8'h0C, 8'hC0};
        send_frame();
        // Q bit clear
        frame_q = '{8'hF0, 8'h80};
        send_frame();
        // One byte too many for a frame without speech bits
        build_frame(1'b0, 4'd9, 4'd3);
        frame_q.push_back(8'h00);
        send_frame();
        wait_idle();
    endtask

    // Frame types without speech bits in both formats, and octet-aligned header errors.
    task automatic test_zero_bit_frames();
        build_frame(1'b0, 4'd15, 4'd15);
        send_frame();
        wait_idle();
        write_reg(REG_OCTET_ALIGNED, 8'h01);
        build_frame(1'b1, 4'd9, 4'd15);
        send_frame();
        // F bit set, then Q bit clear
        frame_q = '{8'h00, 8'h80};
        send_frame();
        frame_q = '{8'hFF, 8'h7B};
        send_frame();
        wait_idle();
    endtask

    // Mode requests against a sparse allowed set, including one with no candidate.
    task automatic test_mode_requests();
        configure(1'b0, 8'b0010_0101, 3'd7, 1'b1);
        build_frame(1'b0, 4'd10, 4'd6);
        send_frame();
        build_frame(1'b0, 4'd10, 4'd1);
        send_frame();
        build_frame(1'b0, 4'd10, 4'd15);
        send_frame();
        wait_idle();
        write_reg(REG_ALLOWED_MODES, 8'hF0);
        build_frame(1'b0, 4'd10, 4'd2);
        send_frame();
        wait_idle();
    endtask

    // Largest and smallest nonzero frame types in both formats and a payload that overruns the buffer.
    task automatic test_long_payloads();
        configure(1'b1, 8'hFF, 3'd0, 1'b1);
        build_frame(1'b1, 4'd7, 4'd7);
        send_frame();
        build_frame(1'b1, 4'd8, 4'd4);
        send_frame();
        wait_idle();
        write_reg(REG_OCTET_ALIGNED, 8'h00);
        build_frame(1'b0, 4'd7, 4'd0);
        send_frame();
        build_frame(1'b0, 4'd8, 4'd5);
        send_frame();
        build_frame(1'b0, 4'd7, 4'd7);
        while (frame_q.size() < 70) frame_q.push_back(8'($urandom_range(0, 255)));
        send_frame();
        wait_idle();
    endtask

    // Mostly well-formed frames with random content, the rest broken or noise.
    task automatic send_random_payload();
        int roll;
        roll = $urandom_range(0, 19);
        build_frame(oa_mode, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        if (roll >= 14 && roll < 16) begin
            if (oa_mode)
                frame_q[1] = frame_q[1] ^ ($urandom_range(0, 1) ? 8'h80 : 8'h04);
            else if ($urandom_range(0, 1))
                frame_q[0] = frame_q[0] ^ 8'h08;
            else
                frame_q[1] = frame_q[1] ^ 8'h40;
        end else if (roll >= 16 && roll < 18) begin
            if ($urandom_range(0, 1))
                void'(frame_q.pop_back());
            else
                frame_q.push_back(8'($urandom_range(0, 255)));
        end else if (roll == 18) begin
            frame_q = '{8'h00};
            frame_q[0] = 8'($urandom_range(0, 255));
        end else if (roll == 19) begin
            frame_q.delete();
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(65, 70) : $urandom_range(1, 40))
                frame_q.push_back(8'($urandom_range(0, 255)));
        end
        send_frame();
    endtask

    // Random traffic over several register settings; the last phase runs without input gaps or back-pressure.
    task automatic test_random_traffic();
        int phase_goal;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: configure(1'b1, 8'hFF, 3'd0, 1'b1);
                1: configure(1'b0, 8'h00, 3'd7, 1'b1);
                default: configure(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                   3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            endcase
            quiet = (p == PHASES - 1);
            phase_goal = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < phase_goal) send_random_payload();
            wait_idle();
        end
    endtask

    // Output side back-pressure in random bursts.
    always @(posedge aclk) begin : sink_pacing
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 16);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each output transaction with the oldest expected result.
    always @(posedge aclk) begin : result_check
        storage_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_storage.size() == 0) begin
                report_mismatch("unexpected result, tdata", m_tdata, 0);
            end else begin
                want = pending_storage.pop_front();
                check_field("storage_byte", m_tdata[7:0], want.sbyte);
                check_field("frame_type", m_tdata[11:8], want.ftype);
                check_field("requested_mode", m_tdata[15:12], want.cmr);
                check_field("active_mode", m_tdata[18:16], want.mode);
                check_field("tdata padding", m_tdata[23:19], 0);
                check_field("result_last", m_tlast, want.fin);
                check_field("frame_status", m_tuser, want.status);
            end
            results_checked++;
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("amr_rtp_payload_depacketizer_unit: mismatch");
            $finish;
        end
    end

    initial begin
        pl_count      = 7'd0;
        cur_mode      = 3'd7;
        oa_mode       = 1'b0;
        allowed_modes = 8'hFF;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_short_and_bad_headers();
        test_zero_bit_frames();
        test_mode_requests();
        test_long_payloads();
        test_random_traffic();
        wait_idle();

        $write("Sent %0d payload bytes in %0d payloads: ", items_sent, payloads_sent);
        $display("%0d good, %0d too short, %0d bad header, %0d bad length.",
                 good_frames, short_frames, hdr_errors, len_errors);
        $display("Checked %0d output transactions under %0d register writes in both formats.",
                 results_checked, cfg_writes);
        if (mismatches == 0) begin
            $display("amr_rtp_payload_depacketizer_unit: match");
        end else begin
            $display("amr_rtp_payload_depacketizer_unit: mismatch");
        end
        $finish;
    end

endmodule
